[design/address_table_heap_allocator_macros.svh]
// Assertion macros for the address table heap allocator.
// Used by the top level only; needs nothing else.
`ifndef ADDRESS_TABLE_HEAP_ALLOCATOR_MACROS_SVH
`define ADDRESS_TABLE_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ATHP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ATHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/athp_pkg.sv]
// Shared types and constants of the address table heap allocator.
// No dependencies; used by the engine and the top level.
package athp_pkg;

    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_ALLOC  = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;
    localparam logic [1:0] OP_RESIZE = 2'd3;

    localparam logic [1:0] REG_HEAP_START = 2'd0;
    localparam logic [1:0] REG_HEAP_END   = 2'd1;
    localparam logic [1:0] REG_MAX_BLOCK  = 2'd2;

    localparam logic [31:0] RESET_HEAP_START = 32'h2001_0000;
    localparam logic [31:0] RESET_HEAP_END   = 32'h2001_C000;
    localparam logic [20:0] RESET_MAX_BLOCK  = 21'd4096;

    // Bit 0 of a table entry is the reserved mark.
    localparam logic [31:0] ADDR_PART = 32'hFFFF_FFFE;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] request_size;
        logic [31:0] block_address;
    } t_in;

    typedef struct packed {
        logic [31:0] result_address;
        logic        status;
        logic        copy_needed;
        logic [31:0] copy_source;
        logic [31:0] copy_length;
    } t_out;

    typedef struct packed {
        logic [31:0] heap_start;
        logic [31:0] heap_end;
        logic [20:0] max_block;
    } t_cfg;

    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_stat;

endpackage

[design/athp_ram.sv]
// Block table storage: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module athp_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_q;

endmodule

[design/athp_engine.sv]
// Operation sequencer: scans the block table one entry per cycle and
// performs init, allocate, free and resize. Depends on athp_pkg.
module athp_engine import athp_pkg::*; #(
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_req_valid,
    input  t_in                      i_req,
    input  logic                     i_out_free,
    output t_eng_stat                o_stat,
    output t_out                     o_res,
    output logic [$clog2(DEPTH)-1:0] o_rd_addr,
    input  logic [31:0]              i_rd_data,
    output logic                     o_wr_en,
    output logic [$clog2(DEPTH)-1:0] o_wr_addr,
    output logic [31:0]              o_wr_data
);

    localparam int unsigned IW = $clog2(DEPTH);
    localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
    localparam t_out RES_FAIL = '{
        result_address: 32'd0, status: 1'b1, copy_needed: 1'b0,
        copy_source: 32'd0, copy_length: 32'd0
    };

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ASCAN, S_AW2, S_FSCAN, S_RSCAN,
        S_RDEC, S_RCLR, S_RCLR2, S_DONE
    } t_state;

    t_state        r_state;
    logic [IW-1:0] r_idx;
    logic          r_issue;
    logic          r_dv;
    logic [IW-1:0] r_didx;
    logic [31:0]   r_prev;
    logic [31:0]   r_clr_first;
    logic          r_clr_reply;
    t_in           r_req;
    logic [20:0]   r_n;
    logic          r_size_ok;
    logic          r_hit;
    logic          r_found;
    logic [IW-1:0] r_slot;
    logic [31:0]   r_p1;
    logic [31:0]   r_gap;
    logic          r_resize;
    logic [IW-1:0] r_wa;
    logic [31:0]   r_wd;
    t_out          r_res;

    logic [31:0] q_addr;
    logic        last;
    logic        match;
    logic [31:0] diff;
    logic        fit_ok;
    logic [32:0] sum;
    logic        over;
    logic        in_heap;
    logic [32:0] n33;
    logic        size_ok;
    logic [31:0] gap;
    logic        scanning;

    always_comb begin
        q_addr   = i_rd_data & ADDR_PART;
        last     = (r_didx == LAST);
        match    = (q_addr == r_req.block_address);
        diff     = q_addr - r_prev;
        fit_ok   = !r_prev[0] && ((i_rd_data == 32'd0) || (diff >= {11'd0, r_n}));
        sum      = {1'b0, r_prev} + {12'd0, r_n};
        over     = (sum > {1'b0, i_cfg.heap_end});
        in_heap  = (i_req.block_address >= i_cfg.heap_start) &&
                   (i_req.block_address < i_cfg.heap_end);
        n33      = ({1'b0, i_req.request_size} + 33'd3) & ~33'd3;
        size_ok  = (n33 != 33'd0) && (n33 <= {12'd0, i_cfg.max_block});
        gap      = ((q_addr != 32'd0) && (q_addr >= r_p1)) ? (q_addr - r_p1) : 32'd0;
        scanning = (r_state == S_ASCAN) || (r_state == S_FSCAN) || (r_state == S_RSCAN);
    end

    // Table write port.
    always_comb begin
        o_wr_en   = 1'b0;
        o_wr_addr = r_idx;
        o_wr_data = 32'd0;
        case (r_state)
            S_CLEAR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx;
                o_wr_data = (r_idx == '0) ? r_clr_first : 32'd0;
            end
            S_ASCAN: begin
                o_wr_en   = r_dv && (r_didx != '0) && fit_ok && !over;
                o_wr_addr = r_didx - IW'(1);
                o_wr_data = r_prev | 32'd1;
            end
            S_AW2: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_wa;
                o_wr_data = r_wd;
            end
            S_FSCAN: begin
                o_wr_en   = r_dv && match;
                o_wr_addr = r_didx;
                o_wr_data = q_addr;
            end
            S_RCLR2: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_slot;
                o_wr_data = q_addr;
            end
            default: begin
                o_wr_en = 1'b0;
            end
        endcase
    end

    assign o_rd_addr   = (r_state == S_RCLR) ? r_slot : r_idx;
    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_issue     <= 1'b0;
            r_dv        <= 1'b0;
            r_clr_first <= RESET_HEAP_START & ADDR_PART;
            r_clr_reply <= 1'b0;
            r_resize    <= 1'b0;
        end else begin
            // Read pipeline shared by all scans: the data of an entry arrives in the cycle after its address.
            if (scanning) begin
                r_dv   <= r_issue;
                r_didx <= r_idx;
                if (r_issue) begin
                    if (r_idx == LAST) begin
                        r_issue <= 1'b0;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
            end

            case (r_state)
                S_CLEAR: begin
                    if (r_idx == LAST) begin
                        r_state <= r_clr_reply ? S_DONE : S_IDLE;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end

                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req     <= i_req;
                        r_n       <= n33[20:0];
                        r_size_ok <= size_ok;
                        r_hit     <= 1'b0;
                        r_found   <= 1'b0;
                        r_resize  <= 1'b0;
                        r_idx     <= '0;
                        r_issue   <= 1'b1;
                        r_dv      <= 1'b0;
                        case (i_req.operation)
                            OP_INIT: begin
                                r_res       <= '0;
                                r_clr_first <= i_cfg.heap_start & ADDR_PART;
                                r_clr_reply <= 1'b1;
                                r_state     <= S_CLEAR;
                            end
                            OP_ALLOC: begin
                                if (size_ok) begin
                                    r_res   <= '0;
                                    r_state <= S_ASCAN;
                                end else begin
                                    r_res   <= RES_FAIL;
                                    r_state <= S_DONE;
                                end
                            end
                            OP_FREE: begin
                                if (in_heap) begin
                                    r_res   <= '0;
                                    r_state <= S_FSCAN;
                                end else begin
                                    r_res   <= RES_FAIL;
                                    r_state <= S_DONE;
                                end
                            end
                            OP_RESIZE: begin
                                if (in_heap) begin
                                    r_res   <= '0;
                                    r_state <= S_RSCAN;
                                end else begin
                                    r_res   <= RES_FAIL;
                                    r_state <= S_DONE;
                                end
                            end
                            default: begin
                                r_res   <= RES_FAIL;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end

                S_ASCAN: begin
                    if (r_dv) begin
                        r_prev <= i_rd_data;
                        // The pair under test is the previous entry and this one.
                        if ((r_didx != '0) && fit_ok) begin
                            if (over) begin
                                r_res   <= RES_FAIL;
                                r_state <= S_DONE;
                            end else begin
                                r_res.result_address <= r_prev;
                                if (i_rd_data == 32'd0) begin
                                    r_wa    <= r_didx;
                                    r_wd    <= sum[31:0];
                                    r_state <= S_AW2;
                                end else begin
                                    r_state <= r_resize ? S_RCLR : S_DONE;
                                end
                            end
                        end else if (last) begin
                            r_res   <= RES_FAIL;
                            r_state <= S_DONE;
                        end
                    end
                end

                S_AW2: begin
                    r_state <= r_resize ? S_RCLR : S_DONE;
                end

                S_FSCAN: begin
                    if (r_dv) begin
                        if (match) begin
                            r_hit <= 1'b1;
                        end
                        if (last) begin
                            r_res.status <= !(r_hit || match);
                            r_state      <= S_DONE;
                        end
                    end
                end

                S_RSCAN: begin
                    if (r_dv) begin
                        if (!r_found) begin
                            if (match) begin
                                r_found <= 1'b1;
                                r_slot  <= r_didx;
                                r_p1    <= q_addr;
                                if (last) begin
                                    r_gap   <= 32'd0;
                                    r_state <= S_RDEC;
                                end
                            end else if (last) begin
                                r_res   <= RES_FAIL;
                                r_state <= S_DONE;
                            end
                        end else begin
                            // This is the entry after the old block.
                            r_gap   <= gap;
                            r_state <= S_RDEC;
                        end
                    end
                end

                S_RDEC: begin
                    if (r_req.request_size <= r_gap) begin
                        r_res.result_address <= r_p1;
                        r_state              <= S_DONE;
                    end else if (!r_size_ok) begin
                        r_res   <= RES_FAIL;
                        r_state <= S_DONE;
                    end else begin
                        r_resize <= 1'b1;
                        r_idx    <= '0;
                        r_issue  <= 1'b1;
                        r_dv     <= 1'b0;
                        r_state  <= S_ASCAN;
                    end
                end

                // The old entry is read again, since the allocation may have
                // rewritten it.
                S_RCLR: begin
                    r_state <= S_RCLR2;
                end

                S_RCLR2: begin
                    r_res.copy_needed <= 1'b1;
                    r_res.copy_source <= r_p1;
                    r_res.copy_length <= r_gap;
                    r_state           <= S_DONE;
                end

                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[design/address_table_heap_allocator.sv]
// Channel   | Direction | Handshake                | Payload
// request   | in        | i_in_valid / o_in_stall  | i_in_data  (t_in)
// result    | out       | o_out_valid / i_out_stall | o_out_data (t_out)
// config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request at a time; the table scan reads one entry per cycle from the table RAM.
// After reset a clearing pass over all TABLE_ENTRIES entries runs before the first request is taken.
// A finished result sits in the output register, so a new request is taken while it is stalled.
// Top level of the address table heap allocator.
// Depends on athp_pkg, athp_ram, athp_engine and the macros header.
`include "address_table_heap_allocator_macros.svh"

module address_table_heap_allocator import athp_pkg::*; #(
    parameter int unsigned TABLE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int unsigned IW = $clog2(TABLE_ENTRIES);

    t_cfg          r_cfg;
    logic          r_out_valid;
    t_out          r_out_data;
    t_eng_stat     eng_stat;
    t_out          eng_res;
    logic          in_accept;
    logic          out_free;
    logic          res_load;
    logic          out_failed;
    logic          fail_clean;
    logic          out_copy;
    logic [IW-1:0] rd_addr;
    logic [31:0]   rd_data;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !eng_stat.idle;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign res_load    = eng_stat.done && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign out_failed = r_out_valid && r_out_data.status;
    assign fail_clean = (r_out_data.result_address == 32'd0) && !r_out_data.copy_needed;
    assign out_copy   = r_out_valid && r_out_data.copy_needed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.heap_start <= RESET_HEAP_START;
            r_cfg.heap_end   <= RESET_HEAP_END;
            r_cfg.max_block  <= RESET_MAX_BLOCK;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_HEAP_START: r_cfg.heap_start <= i_cfg_data;
                REG_HEAP_END:   r_cfg.heap_end   <= i_cfg_data;
                REG_MAX_BLOCK:  r_cfg.max_block  <= i_cfg_data[20:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
            r_out_data  <= eng_res;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    athp_engine #(
        .DEPTH(TABLE_ENTRIES)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_req_valid(in_accept),
        .i_req      (i_in_data),
        .i_out_free (out_free),
        .o_stat     (eng_stat),
        .o_res      (eng_res),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    athp_ram #(
        .DEPTH(TABLE_ENTRIES),
        .WIDTH(32)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    `ATHP_ASSERT_IMPL(a_fail_clean, i_clk, i_rst_n, out_failed, fail_clean, "failure carries data")
    `ATHP_ASSERT_IMPL(a_copy_success, i_clk, i_rst_n, out_copy, !r_out_data.status, "failed copy")
    `ATHP_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, in_accept, o_in_stall, "still idle")
    `ATHP_ASSERT_NEXT(a_load_on_done, i_clk, i_rst_n, res_load, r_out_valid, "result not loaded")

endmodule
